### hdl/mbf_pkg.sv
// Shared types and constants for the multichannel biquad filter.
`default_nettype none

package mbf_pkg;

   localparam int SAMPLE_W   = 24;
   localparam int COEF_W     = 32;
   localparam int CHAN_W     = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int PROD_W     = SAMPLE_W + COEF_W;
   localparam int ACC_W      = PROD_W + 3;
   localparam int FRAC_SHIFT = 28;
   localparam int Q_W        = ACC_W - FRAC_SHIFT;

   localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (FRAC_SHIFT - 1);

   localparam logic [CSR_ADDR_W-1:0] CSR_COEF_FF0      = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_COEF_FF1      = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_COEF_FF2      = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_COEF_FB1      = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_COEF_FB2      = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_FILTER_ENABLE = 3'd5;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [COEF_W-1:0]   coef_type;
   typedef logic signed [PROD_W-1:0]   prod_type;

   localparam sample_type SAT_MAX = 24'sh7FFFFF;
   localparam sample_type SAT_MIN = -24'sh800000;

   // One history memory word: last two inputs and last two outputs.
   typedef struct packed {
      sample_type x1;
      sample_type x2;
      sample_type y1;
      sample_type y2;
   } hist_word_type;

endpackage

`default_nettype wire

### hdl/multichannel_biquad_filter_core.sv
// Multichannel direct-form-I biquad filter core with per-channel history memory.
`default_nettype none

//  Channel | Ports                                          | Transfer when
//  --------+------------------------------------------------+------------------------
//  request | req_valid req_stall req_chan req_sample_in     | req_valid && !req_stall
//  result  | rsp_valid rsp_stall rsp_chan_out rsp_sample_out| rsp_valid && !rsp_stall
//  config  | csr_wr_en csr_addr csr_wr_data                 | csr_wr_en
//
//  The result of a sample transfer passes through stages 1, 2 and 3 and the
//  result register before it reaches the rsp ports. Samples of different channels
//  enter one per cycle unless the result side stalls; a sample whose channel is
//  still in the pipeline waits until that channel's history has been written back
//  to memory, so a channel takes no new sample before that write-back (the feedback
//  loop through the multipliers, the adder and the history memory port).
//  Reset is synchronous and clears coefficients, enables filtering and marks every
//  history entry as zero through per-channel valid bits. Stages advance
//  independently, so bubbles close up while the result register is stalled.

module multichannel_biquad_filter_core #(
   parameter int CHANNELS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic        [mbf_pkg::CHAN_W-1:0]     req_chan,
   input  logic signed [mbf_pkg::SAMPLE_W-1:0]   req_sample_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic        [mbf_pkg::CHAN_W-1:0]     rsp_chan_out,
   output logic signed [mbf_pkg::SAMPLE_W-1:0]   rsp_sample_out,
   input  logic                                  csr_wr_en,
   input  logic        [mbf_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic        [mbf_pkg::COEF_W-1:0]     csr_wr_data
);

   import mbf_pkg::*;

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CX_W  = (IDX_W > CHAN_W) ? IDX_W : CHAN_W;

   // Configuration registers.
   coef_type coef_ff0_ff, coef_ff1_ff, coef_ff2_ff, coef_fb1_ff, coef_fb2_ff;
   logic     enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff0_ff <= '0;
         coef_ff1_ff <= '0;
         coef_ff2_ff <= '0;
         coef_fb1_ff <= '0;
         coef_fb2_ff <= '0;
         enable_ff   <= 1'b1;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            CSR_COEF_FF0:      coef_ff0_ff <= coef_type'(csr_wr_data);
            CSR_COEF_FF1:      coef_ff1_ff <= coef_type'(csr_wr_data);
            CSR_COEF_FF2:      coef_ff2_ff <= coef_type'(csr_wr_data);
            CSR_COEF_FB1:      coef_fb1_ff <= coef_type'(csr_wr_data);
            CSR_COEF_FB2:      coef_fb2_ff <= coef_type'(csr_wr_data);
            CSR_FILTER_ENABLE: enable_ff   <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   // Pipeline registers.
   logic                s1_vld_ff, s2_vld_ff, s3_vld_ff, rsp_vld_ff;
   logic                s1_vld_in, s2_vld_in, s3_vld_in, rsp_vld_in;
   logic                s1_act_ff, s2_act_ff, s3_act_ff;
   logic [CHAN_W-1:0]   s1_chan_ff, s2_chan_ff, s3_chan_ff, rsp_chan_ff;
   sample_type          s1_x_ff, s2_x_ff, s3_x_ff, rsp_sample_ff;
   sample_type          s2_x1_ff, s2_y1_ff, s3_x1_ff, s3_y1_ff;
   logic                s1_hvld_ff;
   hist_word_type       hist_rd_ff;
   prod_type            p0_ff, p1_ff, p2_ff, p3_ff, p4_ff;
   logic [ACC_W-1:0]    acc_ff;

   // History memory and its per-channel valid bits.
   hist_word_type       hist_mem [CHANNELS];
   logic [CHANNELS-1:0] hist_vld_ff;

   // Handshake and flow control.
   logic             rsp_ld, s3_ld, s2_ld, s1_ld;
   logic             req_fire, req_act, hazard;
   logic [CX_W-1:0]  req_cx;
   logic [IDX_W-1:0] req_idx;

   assign rsp_ld = !rsp_vld_ff || !rsp_stall;
   assign s3_ld  = !s3_vld_ff || rsp_ld;
   assign s2_ld  = !s2_vld_ff || s3_ld;
   assign s1_ld  = !s1_vld_ff || s2_ld;

   // A sample is filtered only when filtering is on and its channel exists.
   assign req_act = enable_ff && (32'(req_chan) < 32'(CHANNELS));
   assign req_cx  = CX_W'(req_chan);
   assign req_idx = req_cx[IDX_W-1:0];

   // Interlock: the history of a channel must be written back before the next
   // sample of that channel reads it.
   assign hazard = req_act &&
                   ((s1_vld_ff && s1_act_ff && (s1_chan_ff == req_chan)) ||
                    (s2_vld_ff && s2_act_ff && (s2_chan_ff == req_chan)) ||
                    (s3_vld_ff && s3_act_ff && (s3_chan_ff == req_chan)));

   assign req_stall = !s1_ld || hazard;
   assign req_fire  = req_valid && !req_stall;

   assign s1_vld_in  = s1_ld  ? req_fire  : s1_vld_ff;
   assign s2_vld_in  = s2_ld  ? s1_vld_ff : s2_vld_ff;
   assign s3_vld_in  = s3_ld  ? s2_vld_ff : s3_vld_ff;
   assign rsp_vld_in = rsp_ld ? s3_vld_ff : rsp_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         s2_vld_ff  <= s2_vld_in;
         s3_vld_ff  <= s3_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Stage 1 captures the sample while the memory returns the channel history.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_act_ff  <= req_act;
         s1_chan_ff <= req_chan;
         s1_x_ff    <= req_sample_in;
      end
   end

   // Stage 2: five products. An entry never written since reset reads as zero.
   hist_word_type hist_cur;
   assign hist_cur = s1_hvld_ff ? hist_rd_ff : '0;

   always_ff @(posedge clock) begin
      if (s1_vld_ff && s2_ld) begin
         p0_ff      <= PROD_W'(s1_x_ff)     * PROD_W'(coef_ff0_ff);
         p1_ff      <= PROD_W'(hist_cur.x1) * PROD_W'(coef_ff1_ff);
         p2_ff      <= PROD_W'(hist_cur.x2) * PROD_W'(coef_ff2_ff);
         p3_ff      <= PROD_W'(hist_cur.y1) * PROD_W'(coef_fb1_ff);
         p4_ff      <= PROD_W'(hist_cur.y2) * PROD_W'(coef_fb2_ff);
         s2_act_ff  <= s1_act_ff;
         s2_chan_ff <= s1_chan_ff;
         s2_x_ff    <= s1_x_ff;
         s2_x1_ff   <= hist_cur.x1;
         s2_y1_ff   <= hist_cur.y1;
      end
   end

   // Stage 3: exact sum of the five terms in Q8.51.
   always_ff @(posedge clock) begin
      if (s2_vld_ff && s3_ld) begin
         acc_ff     <= ACC_W'(p0_ff) + ACC_W'(p1_ff) + ACC_W'(p2_ff)
                     - ACC_W'(p3_ff) - ACC_W'(p4_ff);
         s3_act_ff  <= s2_act_ff;
         s3_chan_ff <= s2_chan_ff;
         s3_x_ff    <= s2_x_ff;
         s3_x1_ff   <= s2_x1_ff;
         s3_y1_ff   <= s2_y1_ff;
      end
   end

   // Round half up to Q1.23, then saturate.
   logic [ACC_W-1:0]    acc_rnd;
   logic signed [Q_W-1:0] acc_q;
   sample_type          y_sat, s3_y;

   assign acc_rnd = acc_ff + ROUND_BIAS;
   assign acc_q   = $signed(acc_rnd[ACC_W-1:FRAC_SHIFT]);

   always_comb begin
      if (acc_q > Q_W'(SAT_MAX)) begin
         y_sat = SAT_MAX;
      end else if (acc_q < Q_W'(SAT_MIN)) begin
         y_sat = SAT_MIN;
      end else begin
         y_sat = acc_q[SAMPLE_W-1:0];
      end
   end

   // A passed-through sample leaves unchanged and touches no history.
   assign s3_y = s3_act_ff ? y_sat : s3_x_ff;

   // Write-back of the updated history as the result moves to the output.
   logic             wb_en;
   logic [CX_W-1:0]  wb_cx;
   logic [IDX_W-1:0] wb_idx;
   hist_word_type    wb_word;

   assign wb_en   = s3_vld_ff && s3_act_ff && rsp_ld;
   assign wb_cx   = CX_W'(s3_chan_ff);
   assign wb_idx  = wb_cx[IDX_W-1:0];
   assign wb_word = '{x1: s3_x_ff, x2: s3_x1_ff, y1: y_sat, y2: s3_y1_ff};

   always_ff @(posedge clock) begin
      if (wb_en) begin
         hist_mem[wb_idx] <= wb_word;
      end
      if (req_fire && req_act) begin
         hist_rd_ff <= hist_mem[req_idx];
         s1_hvld_ff <= hist_vld_ff[req_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_vld_ff <= '0;
      end else if (wb_en) begin
         hist_vld_ff[wb_idx] <= 1'b1;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (s3_vld_ff && rsp_ld) begin
         rsp_chan_ff   <= s3_chan_ff;
         rsp_sample_ff <= s3_y;
      end
   end

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_chan_out   = rsp_chan_ff;
   assign rsp_sample_out = rsp_sample_ff;

endmodule

`default_nettype wire
